[sv/timed_motion_command_controller_top_defines.svh]
// assertion macros for the timed motion command controller
// used by the core and the top level, no other dependencies
`ifndef TIMED_MOTION_COMMAND_CONTROLLER_TOP_DEFINES_SVH
`define TIMED_MOTION_COMMAND_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTH

// clocked check, off while reset is low
`define TMCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define TMCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TMCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TMCC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[sv/tmcc_pkg.sv]
// types, codes and constants of the timed motion command controller
// no dependencies
package tmcc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PWM_STEP       = 3'd0,
    REG_PWM_MIN        = 3'd1,
    REG_PWM_MAX        = 3'd2,
    REG_MOTION_TIMEOUT = 3'd3,
    REG_REPORT_IVAL    = 3'd4
  } cfg_idx_t;

  localparam logic [5:0]  PWM_STEP_RST       = 6'd5;
  localparam logic [6:0]  PWM_MIN_RST        = 7'd18;
  localparam logic [6:0]  PWM_MAX_RST        = 7'd100;
  localparam logic [15:0] MOTION_TIMEOUT_RST = 16'd285;
  localparam logic [15:0] REPORT_IVAL_RST    = 16'd100;
  localparam logic [6:0]  DUTY_RST           = 7'd18;

  typedef enum logic [2:0] {
    MODE_STOP  = 3'd0,
    MODE_FWD   = 3'd1,
    MODE_REV   = 3'd2,
    MODE_LEFT  = 3'd3,
    MODE_RIGHT = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REASON_NONE    = 2'd0,
    REASON_STOP    = 2'd1,
    REASON_DUTY    = 2'd2,
    REASON_TIMEOUT = 2'd3
  } reason_t;

  // command characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // yaw wrap limits in tenths of a degree
  localparam logic signed [13:0] HALF_TURN = 14'sd1800;
  localparam logic signed [13:0] FULL_TURN = 14'sd3600;

  // inner wheel duty = duty*3/5; /5 done as *205 >> 10, exact for duty*3 < 1024
  localparam logic [1:0] INNER_NUM   = 2'd3;
  localparam logic [7:0] INNER_RECIP = 8'd205;
  localparam int unsigned INNER_SHIFT = 10;

  typedef struct packed {
    logic [5:0]  pwm_step;
    logic [6:0]  pwm_min;
    logic [6:0]  pwm_max;
    logic [15:0] motion_timeout_ticks;
    logic [15:0] report_interval_ticks;
  } cfg_t;

  typedef struct packed {
    logic               func;
    logic [7:0]         cmd_byte;
    logic signed [11:0] yaw_angle;
    logic               yaw_valid;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0]  wheel_lf;
    logic signed [7:0]  wheel_rf;
    logic signed [7:0]  wheel_lr;
    logic signed [7:0]  wheel_rr;
    logic               drive_enable;
    logic [2:0]         motion_code;
    logic [6:0]         pwm_level;
    logic [1:0]         stop_reason;
    logic signed [11:0] yaw_delta;
    logic               report_valid;
    logic               cmd_unknown;
  } out_item_t;

  typedef struct packed {
    logic signed [7:0] lf;
    logic signed [7:0] rf;
    logic signed [7:0] lr;
    logic signed [7:0] rr;
  } wheels_t;

endpackage

[sv/tmcc_stream_if.sv]
// valid/ready item channel, payload type set per instance
// payload types come from tmcc_pkg
interface tmcc_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/tmcc_cfg_regs.sv]
// configuration register bank, write only
// depends on tmcc_pkg
module tmcc_cfg_regs import tmcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        REG_PWM_STEP:       cfg_nxt.pwm_step = cfg_wdata[5:0];
        REG_PWM_MIN:        cfg_nxt.pwm_min = cfg_wdata[6:0];
        REG_PWM_MAX:        cfg_nxt.pwm_max = cfg_wdata[6:0];
        REG_MOTION_TIMEOUT: cfg_nxt.motion_timeout_ticks = cfg_wdata;
        REG_REPORT_IVAL:    cfg_nxt.report_interval_ticks = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_step              <= PWM_STEP_RST;
      cfg_r.pwm_min               <= PWM_MIN_RST;
      cfg_r.pwm_max               <= PWM_MAX_RST;
      cfg_r.motion_timeout_ticks  <= MOTION_TIMEOUT_RST;
      cfg_r.report_interval_ticks <= REPORT_IVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/tmcc_wheel_mix.sv]
// wheel duty mixing from duty level and motion mode
// depends on tmcc_pkg
module tmcc_wheel_mix import tmcc_pkg::*; (
  input  logic [6:0] duty,
  input  mode_t      mode,
  output wheels_t    wheels
);

  logic [8:0]  duty_x3;
  logic [16:0] prod;
  logic [6:0]  inner_raw;
  logic [6:0]  inner;
  logic signed [7:0] pos_duty;
  logic signed [7:0] neg_duty;
  logic signed [7:0] pos_inner;

  always_comb begin
    duty_x3   = 9'(duty) * 9'(INNER_NUM);
    prod      = 17'(duty_x3) * 17'(INNER_RECIP);
    inner_raw = prod[INNER_SHIFT +: 7];
    inner     = (inner_raw == 7'd0) ? 7'd1 : inner_raw;
    pos_duty  = $signed({1'b0, duty});
    neg_duty  = 8'sd0 - pos_duty;
    pos_inner = $signed({1'b0, inner});
  end

  always_comb begin
    wheels = '0;
    case (mode)
      MODE_FWD:   wheels = '{lf: pos_duty, rf: pos_duty, lr: pos_duty, rr: pos_duty};
      MODE_REV:   wheels = '{lf: neg_duty, rf: neg_duty, lr: neg_duty, rr: neg_duty};
      MODE_LEFT:  wheels = '{lf: pos_inner, rf: pos_duty, lr: pos_inner, rr: pos_duty};
      MODE_RIGHT: wheels = '{lf: pos_duty, rf: pos_inner, lr: pos_duty, rr: pos_inner};
      default:    wheels = '0;
    endcase
  end

endmodule

[sv/tmcc_core.sv]
// motion state, command decode, tick countdown and yaw report
// depends on tmcc_pkg, tmcc_wheel_mix and the assertion macro header
`include "timed_motion_command_controller_top_defines.svh"

module tmcc_core import tmcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  logic [6:0]         duty_r, duty_nxt;
  mode_t              mode_r, mode_nxt;
  logic [15:0]        ticks_left_r, ticks_left_nxt;
  logic [15:0]        tsr_r, tsr_nxt;
  logic signed [11:0] base_r, base_nxt;
  logic               bok_r, bok_nxt;

  logic [7:0]         cmd_up;
  logic [7:0]         duty_sum;
  logic [15:0]        tsr_inc;
  logic signed [13:0] diff;
  logic signed [13:0] diff_wrap;
  reason_t            reason;
  logic               rep;
  logic               unknown;
  logic signed [11:0] delta;
  wheels_t            wheels;

  always_comb begin
    cmd_up = item.cmd_byte;
    if (item.cmd_byte >= CH_LC_A && item.cmd_byte <= CH_LC_Z) begin
      cmd_up = item.cmd_byte - CASE_OFS;
    end
    duty_sum  = {1'b0, duty_r} + {2'b0, cfg.pwm_step};
    tsr_inc   = (tsr_r != 16'hFFFF) ? tsr_r + 16'd1 : tsr_r;
    diff      = 14'(item.yaw_angle) - 14'(base_r);
    diff_wrap = diff;
    if (diff > HALF_TURN) begin
      diff_wrap = diff - FULL_TURN;
    end else if (diff < -HALF_TURN) begin
      diff_wrap = diff + FULL_TURN;
    end
  end

  always_comb begin
    duty_nxt       = duty_r;
    mode_nxt       = mode_r;
    ticks_left_nxt = ticks_left_r;
    tsr_nxt        = tsr_r;
    base_nxt       = base_r;
    bok_nxt        = bok_r;
    reason         = REASON_NONE;
    rep            = 1'b0;
    unknown        = 1'b0;
    delta          = '0;

    if (!item.func) begin
      case (cmd_up) inside
        CH_CR, CH_LF, CH_SPACE: ;
        CH_F, CH_B, CH_L, CH_R: begin
          case (cmd_up)
            CH_F:    mode_nxt = MODE_FWD;
            CH_B:    mode_nxt = MODE_REV;
            CH_L:    mode_nxt = MODE_LEFT;
            default: mode_nxt = MODE_RIGHT;
          endcase
          ticks_left_nxt = cfg.motion_timeout_ticks;
          tsr_nxt        = '0;
          base_nxt       = item.yaw_angle;
          bok_nxt        = item.yaw_valid;
        end
        CH_PLUS: begin
          mode_nxt = MODE_STOP;
          bok_nxt  = 1'b0;
          reason   = REASON_DUTY;
          if (duty_sum <= {1'b0, cfg.pwm_max}) begin
            duty_nxt = duty_sum[6:0];
          end
        end
        CH_MINUS: begin
          mode_nxt = MODE_STOP;
          bok_nxt  = 1'b0;
          reason   = REASON_DUTY;
          if (duty_r > cfg.pwm_min) begin
            // saturate at zero rather than wrap
            duty_nxt = (duty_r > {1'b0, cfg.pwm_step}) ? duty_r - {1'b0, cfg.pwm_step} : 7'd0;
          end
        end
        CH_S, CH_ZERO: begin
          mode_nxt = MODE_STOP;
          bok_nxt  = 1'b0;
          reason   = REASON_STOP;
        end
        CH_E, CH_T, CH_W, CH_D, CH_P, CH_H, CH_QUEST: ;
        default: unknown = 1'b1;
      endcase
    end else if (mode_r != MODE_STOP) begin
      if (ticks_left_r <= 16'd1) begin
        ticks_left_nxt = '0;
        mode_nxt       = MODE_STOP;
        bok_nxt        = 1'b0;
        reason         = REASON_TIMEOUT;
      end else begin
        ticks_left_nxt = ticks_left_r - 16'd1;
        tsr_nxt        = tsr_inc;
        if (tsr_inc >= cfg.report_interval_ticks) begin
          tsr_nxt = '0;
          rep     = 1'b1;
          if (bok_r) begin
            delta = diff_wrap[11:0];
          end
        end
      end
    end
  end

  tmcc_wheel_mix u_wheel_mix (
    .duty   (duty_nxt),
    .mode   (mode_nxt),
    .wheels (wheels)
  );

  always_comb begin
    result.wheel_lf     = wheels.lf;
    result.wheel_rf     = wheels.rf;
    result.wheel_lr     = wheels.lr;
    result.wheel_rr     = wheels.rr;
    result.drive_enable = (mode_nxt != MODE_STOP);
    result.motion_code  = mode_nxt;
    result.pwm_level    = duty_nxt;
    result.stop_reason  = reason;
    result.yaw_delta    = delta;
    result.report_valid = rep;
    result.cmd_unknown  = unknown;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r       <= DUTY_RST;
      mode_r       <= MODE_STOP;
      ticks_left_r <= '0;
      tsr_r        <= '0;
      base_r       <= '0;
      bok_r        <= 1'b0;
    end else if (fire) begin
      duty_r       <= duty_nxt;
      mode_r       <= mode_nxt;
      ticks_left_r <= ticks_left_nxt;
      tsr_r        <= tsr_nxt;
      base_r       <= base_nxt;
      bok_r        <= bok_nxt;
    end
  end

  `TMCC_ASSERT(a_timeout_stops, clk, rst_n,
    fire && item.func && mode_r != MODE_STOP && ticks_left_r <= 16'd1 |=> mode_r == MODE_STOP,
    "expired timeout did not stop the motion")
  `TMCC_ASSERT(a_idle_holds, clk, rst_n,
    !fire |=> $stable(duty_r) && $stable(mode_r) && $stable(ticks_left_r),
    "state changed with no item")
  `TMCC_ASSERT(a_report_no_stop, clk, rst_n,
    result.report_valid |-> result.stop_reason == REASON_NONE,
    "report and stop on one item")
  `TMCC_ASSERT(a_enable_matches_mode, clk, rst_n,
    result.drive_enable == (result.motion_code != MODE_STOP),
    "drive enable disagrees with motion code")

endmodule

[sv/timed_motion_command_controller_top.sv]
// Timed motion command controller. Each input item is a command byte
// (func 0) or a one millisecond tick (func 1) and carries the current yaw;
// each item gives exactly one result item with the four wheel duties, the
// motion code, the duty level and any stop, report or unknown-command flag.
// One item per clock cycle is sustained while the sink is ready: an input
// register feeds a single pass of decode and counter logic that writes the
// motion state and the output register in the same cycle, so an item
// passes the input register and then the output register before its
// result is valid. The output register holds a result while the
// sink stalls and the input register can still take one more item, so in
// ready only drops when both registers are full and the sink is not ready.
// Configuration registers are written through cfg_we/cfg_idx/cfg_wdata at
// any clock edge; writes take effect on the next item and should be made
// while no item is in flight. There are no memories and no clearing pass.
// depends on tmcc_pkg, tmcc_stream_if, tmcc_cfg_regs, tmcc_core and the
// assertion macro header
`include "timed_motion_command_controller_top_defines.svh"

module timed_motion_command_controller_top import tmcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tmcc_stream_if.sink           in_ch,
  tmcc_stream_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  in_r;
  logic      in_v_r, in_v_nxt;
  out_item_t out_r;
  logic      out_v_r, out_v_nxt;
  out_item_t result;
  logic      adv;
  logic      in_take;

  // register bank for the five tuning registers
  tmcc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // held item moves into the output register when that slot is free or draining
  assign adv     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !in_v_r || adv;

  // state update and result computation for the held item
  tmcc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (adv),
    .item   (in_r),
    .result (result)
  );

  // valid bits of the two register slots
  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end

    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_ch.data;
    end
    if (adv) begin
      out_r <= result;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  `TMCC_ASSERT(a_adv_fills_out, clk, rst_n,
    adv |=> out_v_r,
    "processed item left no result")
  `TMCC_ASSERT(a_held_item_kept, clk, rst_n,
    in_v_r && !adv |=> in_v_r && $stable(in_r),
    "waiting item lost or changed")
  `TMCC_ASSERT(a_out_only_from_adv, clk, rst_n,
    !out_v_r |=> !out_v_r || $past(adv),
    "result appeared without an item")

endmodule
